/* hw/rtl/nta_pkg.sv */
// Shared types and codes for the neighbor table.
`default_nettype none
package nta_pkg;
	localparam logic [2:0] K_DISC  = 3'd0;
	localparam logic [2:0] K_DATA  = 3'd1;
	localparam logic [2:0] K_TICK  = 3'd2;
	localparam logic [2:0] K_LOOK  = 3'd3;
	localparam logic [2:0] K_CLEAR = 3'd4;

	localparam logic [1:0] R_CAP      = 2'd0;
	localparam logic [1:0] R_TIMEOUT  = 2'd1;
	localparam logic [1:0] R_INTERVAL = 2'd2;

	typedef enum logic [3:0] {
		EV_ADDED     = 4'd0,
		EV_REFRESHED = 4'd1,
		EV_FULL      = 4'd2,
		EV_DKNOWN    = 4'd3,
		EV_DUNKNOWN  = 4'd4,
		EV_EXPIRED   = 4'd5,
		EV_ANNOUNCE  = 4'd6,
		EV_TICKDONE  = 4'd7,
		EV_LOOKUP    = 4'd8,
		EV_CLEARED   = 4'd9
	} ev_t;

	typedef struct packed {
		logic [63:0] hi;
		logic [63:0] lo;
		logic [31:0] scope;
		logic [47:0] heard;
		logic [47:0] outbound;
	} entry_t;

	typedef struct packed {
		ev_t         ev;
		logic [63:0] hi;
		logic [63:0] lo;
		logic [31:0] scope;
		logic [2:0]  slot;
		logic        found;
		logic [47:0] heard;
		logic [3:0]  cnt;
		logic        last;
	} res_t;
endpackage
`default_nettype wire

/* hw/rtl/nta_mem.sv */
// Entry store: one write port, one registered read port.
`default_nettype none
module nta_mem #(
	parameter int DEPTH = 8,
	parameter int IW = 3
) (
	input  wire                  clk,
	input  wire                  we,
	input  wire [IW-1:0]         waddr,
	input  wire nta_pkg::entry_t wdata,
	input  wire                  re,
	input  wire [IW-1:0]         raddr,
	output nta_pkg::entry_t      rdata
);
	import nta_pkg::*;

	entry_t mem [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

/* hw/rtl/neighbor_table_with_aging.sv */
// Neighbor table top level: sequencer, valid bits, result register.
//
// Input channel (in_valid/in_ready) takes one event beat: kind, address,
// scope and time. in_ready is high only while the sequencer is idle.
// Output channel (out_valid/out_ready) gives one result beat per cycle at
// most; the last beat of an event has last set. A stall on the output holds
// the sequencer in place with the pending beat registered.
// Discovery, data and lookup walk the entry memory, reading and then comparing
// each slot until a hit or the last slot, then write back any update and post
// the result; the next event is taken once the sequencer is back in idle.
// A tick makes one scan pass over all slots, then walks them for expired peers
// and again for announced ones, a beat for each, then a done beat.
// Configuration beats (cfg_valid/cfg_ready) are always taken; write them
// only while idle. Index 0 is the peer cap, 1 the timeout, 2 the interval.
// Reset clears all valid bits and the peer count and loads register
// defaults; entry contents are not cleared.
`default_nettype none
module neighbor_table_with_aging #(
	parameter int PEER_SLOTS = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [31:0] cfg_data,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [2:0]  kind,
	input  wire  [63:0] addr_hi,
	input  wire  [63:0] addr_lo,
	input  wire  [31:0] iface_scope,
	input  wire  [47:0] now_ms,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [3:0]  event_res,
	output logic [63:0] peer_hi,
	output logic [63:0] peer_lo,
	output logic [31:0] res_scope,
	output logic [2:0]  slot,
	output logic        found,
	output logic [47:0] heard_ms,
	output logic [3:0]  peer_count,
	output logic        last
);
	import nta_pkg::*;

	localparam int IW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
	localparam int CW = $clog2(PEER_SLOTS + 1) + 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(PEER_SLOTS - 1);

	typedef enum logic [11:0] {
		ST_IDLE = 12'b000000000001,
		ST_SRD  = 12'b000000000010,
		ST_SCMP = 12'b000000000100,
		ST_ACT  = 12'b000000001000,
		ST_TRD  = 12'b000000010000,
		ST_TCMP = 12'b000000100000,
		ST_XRD  = 12'b000001000000,
		ST_XEM  = 12'b000010000000,
		ST_ARD  = 12'b000100000000,
		ST_AEM  = 12'b001000000000,
		ST_TDN  = 12'b010000000000,
		ST_EMIT = 12'b100000000000
	} state_t;

	state_t state_q;
	logic [3:0]  cap_q;
	logic [31:0] timeout_q, interval_q;
	logic [PEER_SLOTS-1:0] valid_q, exp_q, ann_q;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] idx_q;
	logic          hit_q;
	logic [2:0]    kind_q;
	logic [63:0]   hi_q, lo_q;
	logic [31:0]   scope_q;
	logic [47:0]   now_q;
	res_t          res_q;
	logic          out_valid_q;

	entry_t        rdata, wdata;
	logic          we, re;
	logic [IW-1:0] waddr, raddr;

	logic          ofree, match, last_slot, free_any, full;
	logic [IW-1:0] free_idx;
	logic [48:0]   exp_lim, ann_lim;
	logic          is_exp, is_ann;
	res_t          res_d;
	logic          post;

	nta_mem #(.DEPTH(PEER_SLOTS), .IW(IW)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.re(re), .raddr(raddr), .rdata(rdata)
	);

	assign ofree     = !out_valid_q || out_ready;
	assign match     = valid_q[idx_q] && rdata.hi == hi_q && rdata.lo == lo_q;
	assign last_slot = idx_q == LAST_IDX;
	assign exp_lim   = {1'b0, rdata.heard} + {17'b0, timeout_q};
	assign ann_lim   = {1'b0, rdata.outbound} + {17'b0, interval_q};
	assign is_exp    = {1'b0, now_q} > exp_lim;
	assign is_ann    = {1'b0, now_q} > ann_lim;
	assign full      = cnt_q >= CW'(cap_q) || !free_any;

	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = PEER_SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	always_comb begin
		re    = state_q == ST_SRD || state_q == ST_TRD ||
			(state_q == ST_XRD && exp_q[idx_q]) ||
			(state_q == ST_ARD && ann_q[idx_q]);
		raddr = idx_q;
		we    = 1'b0;
		waddr = idx_q;
		wdata = rdata;
		if (state_q == ST_ACT && ofree) begin
			if (hit_q && (kind_q == K_DISC || kind_q == K_DATA)) begin
				we          = 1'b1;
				wdata.heard = now_q;
			end else if (!hit_q && kind_q == K_DISC && !full) begin
				we       = 1'b1;
				waddr    = free_idx;
				wdata    = '{hi: hi_q, lo: lo_q, scope: scope_q,
					heard: now_q, outbound: now_q};
			end
		end else if (state_q == ST_AEM && ofree) begin
			we             = 1'b1;
			wdata.outbound = now_q;
		end
	end

	// next result beat and the strobe that loads it
	always_comb begin
		post      = 1'b0;
		res_d     = '0;
		res_d.cnt = cnt_q[3:0];
		case (state_q)
			ST_ACT: begin
				post       = ofree;
				res_d.ev   = EV_LOOKUP;
				res_d.hi   = hi_q;
				res_d.lo   = lo_q;
				res_d.last = 1'b1;
				if (hit_q) begin
					res_d.scope = rdata.scope;
					res_d.slot  = 3'(idx_q);
				end
				case (kind_q)
					K_DISC: begin
						if (hit_q) begin
							res_d.ev = EV_REFRESHED;
						end else if (full) begin
							res_d.ev = EV_FULL;
						end else begin
							res_d.ev    = EV_ADDED;
							res_d.scope = scope_q;
							res_d.slot  = 3'(free_idx);
							res_d.cnt   = 4'(cnt_q + 1'b1);
						end
					end
					K_DATA: res_d.ev = hit_q ? EV_DKNOWN : EV_DUNKNOWN;
					default: begin
						res_d.found = hit_q;
						res_d.heard = hit_q ? rdata.heard : 48'd0;
					end
				endcase
			end
			ST_XEM, ST_AEM: begin
				post        = ofree;
				res_d.ev    = (state_q == ST_XEM) ? EV_EXPIRED : EV_ANNOUNCE;
				res_d.hi    = rdata.hi;
				res_d.lo    = rdata.lo;
				res_d.scope = rdata.scope;
				res_d.slot  = 3'(idx_q);
			end
			ST_TDN: begin
				post       = ofree;
				res_d.ev   = EV_TICKDONE;
				res_d.last = 1'b1;
			end
			ST_EMIT: begin
				post       = ofree;
				res_d.ev   = EV_CLEARED;
				res_d.last = 1'b1;
			end
			default: ;
		endcase
	end

	assign cfg_ready = 1'b1;
	assign in_ready  = state_q == ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q      <= 4'd8;
			timeout_q  <= 32'd22000;
			interval_q <= 32'd5200;
		end else if (cfg_valid) begin
			case (cfg_index)
				R_CAP:      cap_q      <= cfg_data[3:0];
				R_TIMEOUT:  timeout_q  <= cfg_data;
				R_INTERVAL: interval_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_q  <= kind;
			hi_q    <= addr_hi;
			lo_q    <= addr_lo;
			scope_q <= iface_scope;
			now_q   <= now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			exp_q       <= '0;
			ann_q       <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			out_valid_q <= post || (out_valid_q && !out_ready);
			if (post) begin
				res_q <= res_d;
			end
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					hit_q <= 1'b0;
					if (in_valid) begin
						if (kind == K_CLEAR) begin
							state_q <= ST_EMIT;
						end else if (kind == K_TICK) begin
							exp_q   <= '0;
							ann_q   <= '0;
							state_q <= ST_TRD;
						end else if (kind == K_DISC || kind == K_DATA ||
								kind == K_LOOK) begin
							state_q <= ST_SRD;
						end
					end
				end
				ST_SRD: state_q <= ST_SCMP;
				ST_SCMP: begin
					if (match) begin
						hit_q   <= 1'b1;
						state_q <= ST_ACT;
					end else if (last_slot) begin
						state_q <= ST_ACT;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_SRD;
					end
				end
				ST_ACT: begin
					if (post) begin
						state_q <= ST_IDLE;
						if (kind_q == K_DISC && !hit_q && !full) begin
							valid_q[free_idx] <= 1'b1;
							cnt_q             <= cnt_q + 1'b1;
						end
					end
				end
				ST_TRD: state_q <= ST_TCMP;
				ST_TCMP: begin
					if (valid_q[idx_q]) begin
						if (is_exp) begin
							exp_q[idx_q]   <= 1'b1;
							valid_q[idx_q] <= 1'b0;
							cnt_q          <= cnt_q - 1'b1;
						end else if (is_ann) begin
							ann_q[idx_q] <= 1'b1;
						end
					end
					if (last_slot) begin
						idx_q   <= '0;
						state_q <= ST_XRD;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_TRD;
					end
				end
				ST_XRD: begin
					if (exp_q[idx_q]) begin
						state_q <= ST_XEM;
					end else if (last_slot) begin
						idx_q   <= '0;
						state_q <= ST_ARD;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_XEM: begin
					if (post) begin
						if (last_slot) begin
							idx_q   <= '0;
							state_q <= ST_ARD;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_XRD;
						end
					end
				end
				ST_ARD: begin
					if (ann_q[idx_q]) begin
						state_q <= ST_AEM;
					end else if (last_slot) begin
						state_q <= ST_TDN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_AEM: begin
					if (post) begin
						if (last_slot) begin
							state_q <= ST_TDN;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_ARD;
						end
					end
				end
				ST_TDN: begin
					if (post) begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					// clear result posts here once the output register frees
					if (post) begin
						valid_q <= '0;
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign event_res  = res_q.ev;
	assign peer_hi    = res_q.hi;
	assign peer_lo    = res_q.lo;
	assign res_scope  = res_q.scope;
	assign slot       = res_q.slot;
	assign found      = res_q.found;
	assign heard_ms   = res_q.heard;
	assign peer_count = res_q.cnt;
	assign last       = res_q.last;

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(PEER_SLOTS))
		else $error("peer count above table size");
	a_cnt_match: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == CW'($countones(valid_q)))
		else $error("peer count differs from valid bits");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (kind == K_DISC || kind == K_DATA ||
		kind == K_TICK || kind == K_LOOK || kind == K_CLEAR)) |=> !in_ready)
		else $error("input taken while event in progress");
`endif
endmodule
`default_nettype wire
